FILE: design/srsg_pkg.sv
// Shared types and constants for the SMA crossover / RSI signal generator.
// Used by every module of the block; no dependencies of its own.
package srsg_pkg;

  // Default ring depth
  localparam int WINDOW_DEF = 256;

  // Ring taps read per request and the length of the tap cell chain
  localparam int NTAP  = 4;
  localparam int NCELL = NTAP + 1;

  // Slot of each tap in the record once it leaves the chain
  localparam int TAP_R  = 0;  // price one RSI window back
  localparam int TAP_R1 = 1;  // price one RSI window plus one back
  localparam int TAP_L  = 2;  // price long_period back
  localparam int TAP_S  = 3;  // price short_period back

  // Depth of the result queue, also the bound on requests in flight
  localparam int OUT_DEPTH = 4;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 17;

  typedef enum logic [CFG_AW-1:0] {
    REG_SHORT      = 3'd0,
    REG_LONG       = 3'd1,
    REG_RSI        = 3'd2,
    REG_OVERSOLD   = 3'd3,
    REG_OVERBOUGHT = 3'd4,
    REG_WEIGHT     = 3'd5
  } reg_idx_e;

  // Register reset values
  localparam logic [7:0]  SHORT_RST = 8'd10;
  localparam logic [7:0]  LONG_RST  = 8'd30;
  localparam logic [7:0]  RSI_RST   = 8'd14;
  localparam logic [6:0]  OS_RST    = 7'd30;
  localparam logic [6:0]  OB_RST    = 7'd70;
  localparam logic [16:0] W_RST     = 17'd0;

  // Weight of 1.0 in Q1.16
  localparam logic [16:0] W_ONE = 17'd65536;

  // RSI values used when the window is short or has no losses
  localparam logic [6:0] RSI_MID = 7'd50;
  localparam logic [6:0] RSI_TOP = 7'd100;

  // Saturation of the seen-price counter
  localparam logic [8:0] SEEN_MAX = 9'd511;

  typedef enum logic [1:0] {
    SIG_HOLD = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } sig_e;

  // One request as it travels through the tap cells
  typedef struct packed {
    logic [31:0]            price;
    logic signed [15:0]     pred;
    logic [31:0]            prev;
    logic [8:0]             n;
    logic [NTAP-1:0][31:0]  taps;
  } item_t;

  // Effective configuration after clamping
  typedef struct packed {
    logic [7:0]  s_eff;
    logic [7:0]  l_eff;
    logic [7:0]  r_eff;
    logic [6:0]  os;
    logic [6:0]  ob;
    logic [16:0] w_eff;
  } cfg_t;

endpackage

FILE: design/srsg_ring.sv
// Price ring: one write port and one registered read port.
// Uses srsg_pkg for the default depth.
module srsg_ring #(
  parameter int WINDOW = srsg_pkg::WINDOW_DEF
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [$clog2(WINDOW)-1:0] waddr_i,
  input  logic [31:0]               wdata_i,
  input  logic                      re_i,
  input  logic [$clog2(WINDOW)-1:0] raddr_i,
  output logic [31:0]               rdata_o
);

  logic [31:0] mem_q [WINDOW];
  logic [31:0] rdata_q;

  // Store the new price
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the tap read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/srsg_tap_cell.sv
// One cell of the tap chain: registers a request, issues its ring read
// and shifts in the tap read by the cell before it. Uses srsg_pkg.
module srsg_tap_cell #(
  parameter int WINDOW = srsg_pkg::WINDOW_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      v_i,
  input  srsg_pkg::item_t           rec_i,
  input  logic [$clog2(WINDOW)-1:0] wp_i,
  input  logic [7:0]                back_i,
  input  logic                      tap_en_i,
  input  logic [31:0]               rd_data_i,
  input  logic                      req_v_i,
  input  logic [$clog2(WINDOW)-1:0] req_addr_i,
  output logic                      v_o,
  output srsg_pkg::item_t           rec_o,
  output logic [$clog2(WINDOW)-1:0] wp_o,
  output logic                      req_v_o,
  output logic [$clog2(WINDOW)-1:0] req_addr_o
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = ((AW > 8) ? AW : 8) + 1;
  localparam logic [CW-1:0] WIN_C = CW'(WINDOW);

  logic            v_q;
  srsg_pkg::item_t rec_q;
  logic [AW-1:0]   wp_q;
  logic [CW-1:0]   wp_ext;
  logic [CW-1:0]   bk_ext;
  logic [CW-1:0]   addr_full;
  srsg_pkg::item_t rec_d;

  // Ring slot of the tap: write pointer minus distance, wrapped at WINDOW
  always_comb begin
    wp_ext = CW'(wp_i);
    bk_ext = CW'(back_i);
    if (wp_ext >= bk_ext) begin
      addr_full = wp_ext - bk_ext;
    end else begin
      addr_full = wp_ext + WIN_C - bk_ext;
    end
  end

  // Claim the read port on load, else pass the neighbor's request along
  assign req_v_o    = (v_i && tap_en_i) ? 1'b1 : req_v_i;
  assign req_addr_o = (v_i && tap_en_i) ? addr_full[AW-1:0] : req_addr_i;

  // Shift the tap of the previous cell into the record
  always_comb begin
    rec_d      = rec_i;
    rec_d.taps = {rec_i.taps[srsg_pkg::NTAP-2:0], rd_data_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_i) begin
      rec_q <= rec_d;
      wp_q  <= wp_i;
    end
  end

  assign v_o   = v_q;
  assign rec_o = rec_q;
  assign wp_o  = wp_q;

endmodule

FILE: design/srsg_score.sv
// Running window sums and the scoring pipeline that turns one request into a
// hold, buy or sell decision. Uses srsg_pkg.
module srsg_score (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  srsg_pkg::cfg_t   cfg_i,
  input  logic             v_i,
  input  srsg_pkg::item_t  rec_i,
  output logic             res_v_o,
  output srsg_pkg::sig_e   res_sig_o
);

  typedef struct packed {
    logic warm;
    logic short_ok;
    logic rsi_short;
  } flags_t;

  localparam logic signed [35:0] HALF     = 36'sd536870912;
  localparam logic signed [35:0] NEG_HALF = -36'sd536870912;

  // Running sums
  logic [39:0] short_q, long_q, gain_q, loss_q;
  logic [39:0] short_d, long_d, gain_d, loss_d;

  // Sum update terms
  logic [31:0] tap_s, tap_l, tap_a, tap_b;
  logic        ge_s, ge_l, has1, has2, up1, dn2;
  logic [8:0]  r1;
  logic [31:0] d1, d2;
  flags_t      flags_d;

  // Stage U
  logic               u_v_q;
  flags_t             u_flags_q;
  logic signed [15:0] u_pred_q;

  // Stage P1
  logic               p1_v_q;
  flags_t             p1_flags_q;
  logic [47:0]        p1_sl_q, p1_ls_q;
  logic [40:0]        p1_tot_q;
  logic [46:0]        p1_g100_q;
  logic               p1_lz_q;
  logic signed [33:0] p1_wp_q;

  // Stage P2
  logic               p2_v_q;
  flags_t             p2_flags_q;
  logic               p2_sup_q;
  logic [47:0]        p2_ost_q, p2_obt_q;
  logic [46:0]        p2_g100_q;
  logic               p2_lz_q;
  logic signed [33:0] p2_wp_q;

  // Stage P3
  logic               p3_v_q;
  logic               p3_warm_q;
  logic signed [19:0] p3_a_q;
  logic signed [33:0] p3_wp_q;
  logic signed [2:0]  score_c;
  logic               adj_up, adj_dn;
  logic [16:0]        omw;
  logic signed [19:0] a_c;

  // Stage P4
  logic               res_v_q;
  srsg_pkg::sig_e     res_sig_q;
  logic signed [35:0] fin_c;
  srsg_pkg::sig_e     sig_c;

  // Window tails and the RSI pair leaving the window
  assign tap_s = rec_i.taps[srsg_pkg::TAP_S];
  assign tap_l = rec_i.taps[srsg_pkg::TAP_L];
  assign tap_a = rec_i.taps[srsg_pkg::TAP_R1];
  assign tap_b = rec_i.taps[srsg_pkg::TAP_R];

  // Add the new price and change, drop what leaves each window
  always_comb begin
    ge_s = rec_i.n >= {1'b0, cfg_i.s_eff};
    ge_l = rec_i.n >= {1'b0, cfg_i.l_eff};
    has1 = rec_i.n != 9'd0;
    r1   = {1'b0, cfg_i.r_eff} + 9'd1;
    has2 = rec_i.n >= r1;
    up1  = rec_i.price > rec_i.prev;
    d1   = up1 ? (rec_i.price - rec_i.prev) : (rec_i.prev - rec_i.price);
    dn2  = tap_b > tap_a;
    d2   = dn2 ? (tap_b - tap_a) : (tap_a - tap_b);

    short_d = short_q + {8'd0, rec_i.price} - (ge_s ? {8'd0, tap_s} : 40'd0);
    long_d  = long_q + {8'd0, rec_i.price} - (ge_l ? {8'd0, tap_l} : 40'd0);
    gain_d  = gain_q + ((has1 && up1) ? {8'd0, d1} : 40'd0)
                     - ((has2 && dn2) ? {8'd0, d2} : 40'd0);
    loss_d  = loss_q + ((has1 && !up1) ? {8'd0, d1} : 40'd0)
                     - ((has2 && !dn2) ? {8'd0, d2} : 40'd0);

    flags_d.warm      = ge_l;
    flags_d.short_ok  = ({1'b0, rec_i.n} + 10'd1) >= {2'b00, cfg_i.s_eff};
    flags_d.rsi_short = rec_i.n < {1'b0, cfg_i.r_eff};
  end

  // Hold the sums; clear them on a period rewrite
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= '0;
      long_q  <= '0;
      gain_q  <= '0;
      loss_q  <= '0;
    end else if (restart_i) begin
      short_q <= '0;
      long_q  <= '0;
      gain_q  <= '0;
      loss_q  <= '0;
    end else if (v_i) begin
      short_q <= short_d;
      long_q  <= long_d;
      gain_q  <= gain_d;
      loss_q  <= loss_d;
    end
  end

  // Advance the valid bits of the scoring stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_v_q   <= 1'b0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      u_v_q   <= v_i;
      p1_v_q  <= u_v_q;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      res_v_q <= p3_v_q;
    end
  end

  // Stage U: keep the flags and predictor next to the fresh sums
  always_ff @(posedge clk_i) begin
    if (v_i) begin
      u_flags_q <= flags_d;
      u_pred_q  <= rec_i.pred;
    end
  end

  // Stage P1: cross-multiply the averages, form RSI terms, weight the predictor
  always_ff @(posedge clk_i) begin
    if (u_v_q) begin
      p1_flags_q <= u_flags_q;
      p1_sl_q    <= 48'(short_q) * 48'(cfg_i.l_eff);
      p1_ls_q    <= 48'(long_q) * 48'(cfg_i.s_eff);
      p1_tot_q   <= 41'(gain_q) + 41'(loss_q);
      p1_g100_q  <= 47'(gain_q) * 47'(srsg_pkg::RSI_TOP);
      p1_lz_q    <= loss_q == 40'd0;
      p1_wp_q    <= 34'($signed({1'b0, cfg_i.w_eff})) * 34'(u_pred_q);
    end
  end

  // Stage P2: compare averages, scale the total by both levels
  always_ff @(posedge clk_i) begin
    if (p1_v_q) begin
      p2_flags_q <= p1_flags_q;
      p2_sup_q   <= p1_flags_q.short_ok && (p1_sl_q > p1_ls_q);
      p2_ost_q   <= 48'(p1_tot_q) * 48'(cfg_i.os);
      p2_obt_q   <= 48'(p1_tot_q) * 48'(cfg_i.ob);
      p2_g100_q  <= p1_g100_q;
      p2_lz_q    <= p1_lz_q;
      p2_wp_q    <= p1_wp_q;
    end
  end

  // Stage P3: build the technical score and weight it by one minus w
  always_comb begin
    adj_up = 1'b0;
    adj_dn = 1'b0;
    if (p2_flags_q.rsi_short) begin
      if (srsg_pkg::RSI_MID < cfg_i.os) begin
        adj_up = 1'b1;
      end else if (srsg_pkg::RSI_MID > cfg_i.ob) begin
        adj_dn = 1'b1;
      end
    end else if (p2_lz_q) begin
      if (srsg_pkg::RSI_TOP < cfg_i.os) begin
        adj_up = 1'b1;
      end else if (srsg_pkg::RSI_TOP > cfg_i.ob) begin
        adj_dn = 1'b1;
      end
    end else begin
      if (48'(p2_g100_q) < p2_ost_q) begin
        adj_up = 1'b1;
      end else if (48'(p2_g100_q) > p2_obt_q) begin
        adj_dn = 1'b1;
      end
    end

    score_c = p2_sup_q ? 3'sd1 : -3'sd1;
    if (adj_up) begin
      score_c = score_c + 3'sd1;
    end else if (adj_dn) begin
      score_c = score_c - 3'sd1;
    end

    omw = srsg_pkg::W_ONE - cfg_i.w_eff;
    case (score_c)
      3'sd2:   a_c = $signed({2'b00, omw, 1'b0});
      3'sd1:   a_c = $signed({3'b000, omw});
      -3'sd1:  a_c = -$signed({3'b000, omw});
      -3'sd2:  a_c = -$signed({2'b00, omw, 1'b0});
      default: a_c = 20'sd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (p2_v_q) begin
      p3_warm_q <= p2_flags_q.warm;
      p3_a_q    <= a_c;
      p3_wp_q   <= p2_wp_q;
    end
  end

  // Stage P4: blend and compare against plus or minus one half
  always_comb begin
    fin_c = (36'(p3_a_q) <<< 14) + (36'(p3_wp_q) <<< 1);
    sig_c = srsg_pkg::SIG_HOLD;
    if (p3_warm_q) begin
      if (fin_c > HALF) begin
        sig_c = srsg_pkg::SIG_BUY;
      end else if (fin_c < NEG_HALF) begin
        sig_c = srsg_pkg::SIG_SELL;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p3_v_q) begin
      res_sig_q <= sig_c;
    end
  end

  assign res_v_o   = res_v_q;
  assign res_sig_o = res_sig_q;

endmodule

FILE: design/sma_rsi_signal_generator.sv
// SMA crossover with RSI adjustment and predictor blend, one signal per price.
// The four ring taps share one read port: a new request is held off until
// the taps of the one before it have been read.
// Up to four results queue at the output; requests stall while four are owed.
// Reset clears counters, sums and queue and loads register defaults; the price
// ring is not cleared (entries read before being written are never used).
module sma_rsi_signal_generator #(
  parameter int WINDOW = srsg_pkg::WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [31:0]                 close_price_i,
  input  logic signed [15:0]          prediction_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  signal_o,
  input  logic                        cfg_we_i,
  input  logic [srsg_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [srsg_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int AW    = $clog2(WINDOW);
  localparam int NCELL = srsg_pkg::NCELL;
  localparam int NTAP  = srsg_pkg::NTAP;
  localparam int QD    = srsg_pkg::OUT_DEPTH;
  localparam int QAW   = $clog2(QD);
  localparam int QCW   = $clog2(QD + 1);
  localparam int SMAX  = (WINDOW - 1 < 255) ? WINDOW - 1 : 255;
  localparam int RMAX  = (WINDOW - 2 < 254) ? WINDOW - 2 : 254;
  localparam logic [7:0]    SMAX8   = 8'(SMAX);
  localparam logic [7:0]    RMAX8   = 8'(RMAX);
  localparam logic [AW-1:0] WP_LAST = AW'(WINDOW - 1);
  localparam logic [QCW-1:0] QFULL  = QCW'(QD);

  // Configuration registers
  logic [7:0]  short_q, long_q, rsi_q;
  logic [6:0]  os_q, ob_q;
  logic [16:0] w_q;
  logic        restart;
  srsg_pkg::cfg_t cfg;

  // Request bookkeeping
  logic          in_acc, out_acc;
  logic [AW-1:0] wp_q;
  logic [8:0]    seen_q;
  logic [31:0]   prev_q;

  // Tap chain
  logic [NCELL:0]  v_c;
  srsg_pkg::item_t rec_c    [NCELL+1];
  logic [AW-1:0]   wp_c     [NCELL+1];
  logic            req_v_c  [NCELL+1];
  logic [AW-1:0]   req_a_c  [NCELL+1];
  logic [7:0]      back_c   [NCELL];
  logic [31:0]     rd_data;

  // Results
  logic           res_v;
  srsg_pkg::sig_e res_sig;
  srsg_pkg::sig_e q_mem_q [QD];
  logic [QAW-1:0] q_wr_q, q_rd_q;
  logic [QCW-1:0] q_cnt_q, q_cnt_d;
  logic [QCW-1:0] cred_q, cred_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Hold the next request while the read port is busy or the queue could fill
  assign in_stall_o = (|v_c[NTAP-1:1]) || (cred_q == QFULL);

  // Write configuration; a period rewrite restarts the warm-up
  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        srsg_pkg::REG_SHORT, srsg_pkg::REG_LONG, srsg_pkg::REG_RSI: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= srsg_pkg::SHORT_RST;
      long_q  <= srsg_pkg::LONG_RST;
      rsi_q   <= srsg_pkg::RSI_RST;
      os_q    <= srsg_pkg::OS_RST;
      ob_q    <= srsg_pkg::OB_RST;
      w_q     <= srsg_pkg::W_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srsg_pkg::REG_SHORT:      short_q <= cfg_data_i[7:0];
        srsg_pkg::REG_LONG:       long_q  <= cfg_data_i[7:0];
        srsg_pkg::REG_RSI:        rsi_q   <= cfg_data_i[7:0];
        srsg_pkg::REG_OVERSOLD:   os_q    <= cfg_data_i[6:0];
        srsg_pkg::REG_OVERBOUGHT: ob_q    <= cfg_data_i[6:0];
        srsg_pkg::REG_WEIGHT:     w_q     <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Clamp periods and weight to their working ranges
  always_comb begin
    cfg.s_eff = (short_q == 8'd0) ? 8'd1 : ((short_q > SMAX8) ? SMAX8 : short_q);
    cfg.l_eff = (long_q == 8'd0) ? 8'd1 : ((long_q > SMAX8) ? SMAX8 : long_q);
    cfg.r_eff = (rsi_q == 8'd0) ? 8'd1 : ((rsi_q > RMAX8) ? RMAX8 : rsi_q);
    cfg.os    = os_q;
    cfg.ob    = ob_q;
    cfg.w_eff = (w_q > srsg_pkg::W_ONE) ? srsg_pkg::W_ONE : w_q;
  end

  // Advance write pointer, seen count and last price per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      seen_q <= '0;
    end else begin
      if (in_acc) begin
        wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
      end
      if (restart) begin
        seen_q <= '0;
      end else if (in_acc && (seen_q < srsg_pkg::SEEN_MAX)) begin
        seen_q <= seen_q + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_q <= close_price_i;
    end
  end

  // Feed the chain head
  always_comb begin
    v_c[0]         = in_acc;
    rec_c[0].price = close_price_i;
    rec_c[0].pred  = prediction_i;
    rec_c[0].prev  = prev_q;
    rec_c[0].n     = seen_q;
    rec_c[0].taps  = '0;
    wp_c[0]        = wp_q;
    req_v_c[0]     = 1'b0;
    req_a_c[0]     = '0;
  end

  // Tap distance of each cell; the last cell only collects
  always_comb begin
    back_c[0] = cfg.s_eff;
    back_c[1] = cfg.l_eff;
    back_c[2] = cfg.r_eff + 8'd1;
    back_c[3] = cfg.r_eff;
    back_c[4] = 8'd0;
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    srsg_tap_cell #(
      .WINDOW (WINDOW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .v_i        (v_c[k]),
      .rec_i      (rec_c[k]),
      .wp_i       (wp_c[k]),
      .back_i     (back_c[k]),
      .tap_en_i   (k < NTAP),
      .rd_data_i  (rd_data),
      .req_v_i    (req_v_c[k]),
      .req_addr_i (req_a_c[k]),
      .v_o        (v_c[k+1]),
      .rec_o      (rec_c[k+1]),
      .wp_o       (wp_c[k+1]),
      .req_v_o    (req_v_c[k+1]),
      .req_addr_o (req_a_c[k+1])
    );
  end

  srsg_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_q),
    .wdata_i (close_price_i),
    .re_i    (req_v_c[NCELL]),
    .raddr_i (req_a_c[NCELL]),
    .rdata_o (rd_data)
  );

  srsg_score u_score (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .cfg_i     (cfg),
    .v_i       (v_c[NCELL]),
    .rec_i     (rec_c[NCELL]),
    .res_v_o   (res_v),
    .res_sig_o (res_sig)
  );

  // Queue results; credits count requests not yet delivered
  assign q_cnt_d = q_cnt_q + QCW'(res_v) - QCW'(out_acc);
  assign cred_d  = cred_q + QCW'(in_acc) - QCW'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
      cred_q  <= '0;
    end else begin
      if (res_v) begin
        q_wr_q <= q_wr_q + QAW'(1);
      end
      if (out_acc) begin
        q_rd_q <= q_rd_q + QAW'(1);
      end
      q_cnt_q <= q_cnt_d;
      cred_q  <= cred_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_v) begin
      q_mem_q[q_wr_q] <= res_sig;
    end
  end

  assign out_valid_o = q_cnt_q != '0;
  assign signal_o    = q_mem_q[q_rd_q];

endmodule

FILE: design/srsg_checker.sv
// Port-level checks for the signal generator, bound to its top level.
// Uses srsg_pkg for the result queue depth.
module srsg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] signal_o
);

  localparam int QCW = $clog2(srsg_pkg::OUT_DEPTH + 1);
  localparam logic [QCW-1:0] QFULL = QCW'(srsg_pkg::OUT_DEPTH);

  logic           in_acc, out_acc;
  logic [QCW-1:0] open_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Track requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + QCW'(in_acc) - QCW'(out_acc);
    end
  end

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(signal_o))
    else $error("result changed while stalled");

  // The read port is shared by four taps: input stays stalled while a request's taps are read
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("request taken before its taps were read");

  // No result without an open request
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> open_q != '0)
    else $error("result without a request");

  // Open requests never exceed the queue depth
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= QFULL)
    else $error("too many open requests");

endmodule

bind sma_rsi_signal_generator srsg_checker u_srsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .signal_o    (signal_o)
);
